>>> hw/rtl/fifo_fill_allocator_macros.svh
// Assertion macros used by the fill allocator checker.
`ifndef FIFO_FILL_ALLOCATOR_MACROS_SVH
`define FIFO_FILL_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define FFA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define FFA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/ffa_pkg.sv
// Shared constants and types of the fill allocator.
package ffa_pkg;

	localparam int unsigned MAX_ORDERS = 64;
	localparam int unsigned ADDR_W     = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
	localparam int unsigned COUNT_W    = $clog2(MAX_ORDERS + 1);

	localparam int unsigned TAG_W   = 32;
	localparam int unsigned STAMP_W = 32;
	localparam int unsigned QTY_W   = 32;
	localparam int unsigned TIF_W   = 2;
	localparam int unsigned TOTAL_W = 38;

	localparam logic             OP_ADD   = 1'b0;
	localparam logic             OP_MATCH = 1'b1;
	localparam logic [TIF_W-1:0] TIF_FOK  = 2'd2;

	typedef struct packed {
		logic [TAG_W-1:0]   tag;
		logic [STAMP_W-1:0] stamp;
		logic [QTY_W-1:0]   size;
	} entry_t;

	localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

>>> hw/rtl/ffa_order_if.sv
// Order channel: valid/ready handshake with the order payload.
interface ffa_order_if;
	import ffa_pkg::*;

	logic               valid;
	logic               ready;
	logic               operation;
	logic [TAG_W-1:0]   order_tag;
	logic [STAMP_W-1:0] arrival_stamp;
	logic [QTY_W-1:0]   quantity;
	logic [TIF_W-1:0]   time_in_force;

	modport source (
		output valid, operation, order_tag, arrival_stamp, quantity, time_in_force,
		input  ready
	);
	modport sink (
		input  valid, operation, order_tag, arrival_stamp, quantity, time_in_force,
		output ready
	);
endinterface

>>> hw/rtl/ffa_report_if.sv
// Report channel: valid/ready handshake with the fill report payload.
interface ffa_report_if;
	import ffa_pkg::*;

	logic             valid;
	logic             ready;
	logic [TAG_W-1:0] report_tag;
	logic [QTY_W-1:0] filled_amount;
	logic             last_report;

	modport source (
		output valid, report_tag, filled_amount, last_report,
		input  ready
	);
	modport sink (
		input  valid, report_tag, filled_amount, last_report,
		output ready
	);
endinterface

>>> hw/rtl/ffa_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
module ffa_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                           wr_data,
	input  logic                                       rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                           rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

>>> hw/rtl/fifo_fill_allocator.sv
// Price-time priority fill allocator: sorted resting book and FIFO fill reports.
// Add transaction: written straight into slot zero when the book is empty, dropped when it is full,
//   else the book is walked down from the newest entry, later stamps moved up; one RAM port pair.
// Incoming transaction: ready again once the last report is loaded, one report for each resting
//   order, one report per cycle while the sink keeps ready high.
// Reset (arst_n low) empties the book and drops any pending report; RAM contents are kept.
module fifo_fill_allocator (
	input  logic         clk,
	input  logic         arst_n,
	ffa_order_if.sink    orders,
	ffa_report_if.source reports
);
	import ffa_pkg::*;

	// Sequencer states, one-hot.
	typedef enum logic [3:0] {
		ST_IDLE    = 4'b0001,  // waiting for a transaction
		ST_INS_CMP = 4'b0010,  // walking down the book, moving later stamps up
		ST_INS_PUT = 4'b0100,  // new order goes into slot zero
		ST_MATCH   = 4'b1000   // streaming fill reports in arrival order
	} state_t;

	state_t              state_q, state_d;
	logic [ADDR_W-1:0]   ptr_q;
	logic [COUNT_W-1:0]  count_q;
	logic [TOTAL_W-1:0]  total_q;
	entry_t              new_entry_q;
	logic [QTY_W-1:0]    rem_q;

	logic                out_valid_q;
	logic [TAG_W-1:0]    out_tag_q;
	logic [QTY_W-1:0]    out_fill_q;
	logic                out_last_q;

	// Book storage.
	logic                ram_wr_en;
	logic [ADDR_W-1:0]   ram_wr_addr;
	logic [ENTRY_W-1:0]  ram_wr_data;
	logic                ram_rd_en;
	logic [ADDR_W-1:0]   ram_rd_addr;
	logic [ENTRY_W-1:0]  ram_rd_data;

	logic                accept;
	logic                book_full;
	logic                book_empty;
	logic [COUNT_W-1:0]  count_m1;
	logic [ADDR_W-1:0]   top_addr;
	logic [COUNT_W-1:0]  ptr_next_cnt;
	logic                is_last;
	logic                out_free;
	logic                killed;
	logic                stamp_gt;
	entry_t              rd_ent;
	entry_t              in_ent;
	logic [QTY_W-1:0]    take;

	assign accept     = orders.valid && orders.ready;
	assign book_full  = (count_q == COUNT_W'(MAX_ORDERS));
	assign book_empty = (count_q == '0);
	assign count_m1   = count_q - COUNT_W'(1);
	assign top_addr   = count_m1[ADDR_W-1:0];

	// Report slot is free when empty or draining this cycle.
	assign out_free   = !out_valid_q || reports.ready;

	assign rd_ent     = entry_t'(ram_rd_data);
	assign in_ent     = '{tag: orders.order_tag, stamp: orders.arrival_stamp,
	                      size: orders.quantity};

	// Insert search: strictly later stamps move up, so equal stamps keep load order.
	assign stamp_gt   = rd_ent.stamp > new_entry_q.stamp;

	// Fill step, the compare/subtract unit of the match walk.
	assign take         = (rd_ent.size < rem_q) ? rd_ent.size : rem_q;
	assign ptr_next_cnt = COUNT_W'(ptr_q) + COUNT_W'(1);
	assign is_last      = (ptr_next_cnt == count_q);

	// Fill-or-kill: the whole quantity must be covered by the resting total.
	assign killed = (orders.time_in_force == TIF_FOK) &&
	                (total_q < TOTAL_W'(orders.quantity));

	assign orders.ready = (state_q == ST_IDLE);

	// RAM control and next state.
	always_comb begin
		state_d     = state_q;
		ram_wr_en   = 1'b0;
		ram_wr_addr = ptr_q + ADDR_W'(1);
		ram_wr_data = ram_rd_data;
		ram_rd_en   = 1'b0;
		ram_rd_addr = ptr_q + ADDR_W'(1);
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (orders.operation == OP_ADD) begin
						if (!book_full && book_empty) begin
							ram_wr_en   = 1'b1;
							ram_wr_addr = '0;
							ram_wr_data = in_ent;
						end else if (!book_full) begin
							// start at the newest entry and walk down
							ram_rd_en   = 1'b1;
							ram_rd_addr = top_addr;
							state_d     = ST_INS_CMP;
						end
					end else if (!book_empty) begin
						ram_rd_en   = 1'b1;
						ram_rd_addr = '0;
						state_d     = ST_MATCH;
					end
				end
			end
			ST_INS_CMP: begin
				ram_wr_en = 1'b1;
				if (stamp_gt) begin
					// move this entry up one slot, fetch the one below
					ram_wr_data = ram_rd_data;
					if (ptr_q == '0) begin
						state_d = ST_INS_PUT;
					end else begin
						ram_rd_en   = 1'b1;
						ram_rd_addr = ptr_q - ADDR_W'(1);
					end
				end else begin
					ram_wr_data = new_entry_q;
					state_d     = ST_IDLE;
				end
			end
			ST_INS_PUT: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = '0;
				ram_wr_data = new_entry_q;
				state_d     = ST_IDLE;
			end
			ST_MATCH: begin
				if (out_free) begin
					if (is_last) begin
						state_d = ST_IDLE;
					end else begin
						ram_rd_en = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// loading a report wins over draining the previous one
			if (state_q == ST_MATCH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (reports.valid && reports.ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_IDLE && accept && orders.operation == OP_ADD && !book_full) begin
				count_q <= count_q + COUNT_W'(1);
				total_q <= total_q + TOTAL_W'(orders.quantity);
			end
			if (state_q == ST_MATCH && out_free && is_last) begin
				// run done: the book empties
				count_q <= '0;
				total_q <= '0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					new_entry_q <= in_ent;
					ptr_q       <= (orders.operation == OP_ADD) ? top_addr : '0;
					rem_q       <= killed ? '0 : orders.quantity;
				end
			end
			ST_INS_CMP: begin
				if (stamp_gt && ptr_q != '0) begin
					ptr_q <= ptr_q - ADDR_W'(1);
				end
			end
			ST_INS_PUT: begin
				ptr_q <= '0;
			end
			ST_MATCH: begin
				if (out_free) begin
					out_tag_q  <= rd_ent.tag;
					out_fill_q <= take;
					out_last_q <= is_last;
					rem_q      <= rem_q - take;
					ptr_q      <= ptr_q + ADDR_W'(1);
				end
			end
			default: begin
				ptr_q <= '0;
			end
		endcase
	end

	ffa_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_ORDERS)
	) u_book (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	assign reports.valid         = out_valid_q;
	assign reports.report_tag    = out_tag_q;
	assign reports.filled_amount = out_fill_q;
	assign reports.last_report   = out_last_q;
endmodule

>>> hw/rtl/ffa_checker.sv
// Port-level checks of the fill allocator, bound to the top level.
`include "fifo_fill_allocator_macros.svh"

module ffa_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     orders_valid,
	input logic                     orders_ready,
	input logic                     orders_operation,
	input logic                     reports_valid,
	input logic                     reports_ready,
	input logic [ffa_pkg::TAG_W-1:0] report_tag,
	input logic [ffa_pkg::QTY_W-1:0] filled_amount,
	input logic                     last_report
);
	import ffa_pkg::*;

	// stalled report holds
	`FFA_ASSERT_NEXT(a_report_hold, reports_valid && !reports_ready, reports_valid && $stable(report_tag) && $stable(filled_amount) && $stable(last_report), "report changed while stalled")

	// an add transaction never creates a report
	`FFA_ASSERT_NEXT(a_add_silent, orders_valid && orders_ready && orders_operation == OP_ADD && !reports_valid, !reports_valid, "report after add")

	// a run in progress blocks new orders
	`FFA_ASSERT_NOW(a_run_busy, reports_valid && !last_report, !orders_ready, "order ready mid-run")

	// reports of one run come back to back
	`FFA_ASSERT_NEXT(a_run_gapless, reports_valid && reports_ready && !last_report, reports_valid, "gap inside a run")
endmodule

bind fifo_fill_allocator ffa_checker u_ffa_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.orders_valid     (orders.valid),
	.orders_ready     (orders.ready),
	.orders_operation (orders.operation),
	.reports_valid    (reports.valid),
	.reports_ready    (reports.ready),
	.report_tag       (reports.report_tag),
	.filled_amount    (reports.filled_amount),
	.last_report      (reports.last_report)
);

>>> bench/tb_top.sv
// Self-checking bench for the price-time fill allocator: sorted book, FIFO fills, FOK kills.
module tb_top;
	import ffa_pkg::*;

	// Time-in-force codes. Only FOK lives in the package. The spare code 3 must behave as DAY.
	localparam logic [TIF_W-1:0] TIF_DAY   = 2'd0;
	localparam logic [TIF_W-1:0] TIF_IOC   = 2'd1;
	localparam logic [TIF_W-1:0] TIF_SPARE = 2'd3;

	localparam int MAX_IDLE     = 18;      // longest gap or stall either side draws
	localparam int RANDOM_ITEMS = 248;     // order transactions in the random part
	// An add can shift a book of up to MAX_ORDERS - 1 entries.
	localparam int DRAIN_CYCLES = 80;
	localparam int CYCLE_LIMIT  = 400000;

	// One expected fill report.
	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [QTY_W-1:0] amount;
		logic             last;
	} fill_t;

	// One row of the directed table. The expected report is typed in only for matches
	// against a single resting order, where the fill can be read off by eye.
	typedef struct {
		logic               op;
		logic [TAG_W-1:0]   tag;
		logic [STAMP_W-1:0] stamp;
		logic [QTY_W-1:0]   qty;
		logic [TIF_W-1:0]   tif;
		bit                 typed;
		logic [TAG_W-1:0]   want_tag;
		logic [QTY_W-1:0]   want_fill;
	} order_row_t;

	logic clk = 1'b0;
	logic arst_n;

	ffa_order_if  orders ();
	ffa_report_if reports ();

	fifo_fill_allocator i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.orders  (orders),
		.reports (reports)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------------------------
	// Shadow book: same ordering rule as the block (ascending stamp, ties keep load
	// order), capped at MAX_ORDERS, and a 38-bit running total for the FOK test.
	// ---------------------------------------------------------------------------------
	entry_t             resting_book[$];
	logic [TOTAL_W-1:0] shadow_total;
	fill_t              expected_fills[$];

	int  orders_accepted  = 0;
	int  adds_accepted    = 0;
	int  adds_dropped     = 0;
	int  matches_accepted = 0;
	int  fok_kills        = 0;
	int  reports_checked  = 0;
	int  mismatches       = 0;
	int  cycle_count      = 0;
	bit  tx_calm          = 1'b0;   // sender runs back to back while set
	bit  rx_calm          = 1'b0;   // receiver keeps ready high while set

	function automatic void rest_order(input logic [TAG_W-1:0] tag,
			input logic [STAMP_W-1:0] stamp, input logic [QTY_W-1:0] size);
		int     pos;
		entry_t e;
		if (resting_book.size() >= MAX_ORDERS) begin
			adds_dropped++;   // full book: silently ignored
			return;
		end
		pos = 0;
		while (pos < resting_book.size() && resting_book[pos].stamp <= stamp)
			pos++;
		e.tag   = tag;
		e.stamp = stamp;
		e.size  = size;
		resting_book.insert(pos, e);
		shadow_total = shadow_total + size;
	endfunction

	// Walk the book oldest first, each order taking min(size, unfilled). A FOK that the
	// book cannot cover is killed and reports zero on every order. The book is emptied.
	function automatic void allocate_fills(input logic [QTY_W-1:0] qty,
			input logic [TIF_W-1:0] tif, ref fill_t fills[$]);
		logic [QTY_W-1:0] unfilled;
		logic [QTY_W-1:0] take;
		fill_t            f;
		if (tif == TIF_FOK && shadow_total < qty) begin
			unfilled = '0;
			if (resting_book.size() != 0)
				fok_kills++;
		end else begin
			unfilled = qty;
		end
		foreach (resting_book[i]) begin
			take     = (resting_book[i].size < unfilled) ? resting_book[i].size : unfilled;
			unfilled = unfilled - take;
			f.tag    = resting_book[i].tag;
			f.amount = take;
			f.last   = (i == resting_book.size() - 1);
			fills.push_back(f);
		end
		resting_book.delete();
		shadow_total = '0;
	endfunction

	// ---------------------------------------------------------------------------------
	// Sender. Gap first (valid low), then hold the transaction until ready is seen at an
	// edge. Values read right after the edge are the pre-edge ones, so the handshake
	// check is free of races with the block's own updates.
	// ---------------------------------------------------------------------------------
	task automatic send_order(input logic op, input logic [TAG_W-1:0] tag,
			input logic [STAMP_W-1:0] stamp, input logic [QTY_W-1:0] qty,
			input logic [TIF_W-1:0] tif, input bit typed = 1'b0,
			input fill_t typed_fill = '0);
		int    gap;
		fill_t fills[$];
		gap = tx_calm ? 0 : $urandom_range(0, MAX_IDLE);
		if (gap != 0) begin
			orders.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		orders.valid         <= 1'b1;
		orders.operation     <= op;
		orders.order_tag     <= tag;
		orders.arrival_stamp <= stamp;
		orders.quantity      <= qty;
		orders.time_in_force <= tif;
		@(posedge clk);
		while (!orders.ready) @(posedge clk);
		orders_accepted++;
		if (op == OP_ADD) begin
			adds_accepted++;
			rest_order(tag, stamp, qty);
		end else begin
			matches_accepted++;
			allocate_fills(qty, tif, fills);
			if (typed)
				expected_fills.push_back(typed_fill);
			else
				foreach (fills[i]) expected_fills.push_back(fills[i]);
		end
	endtask

	// Stamps: mostly a narrow range so that ties are common, now and then full range.
	function automatic logic [STAMP_W-1:0] pick_stamp();
		case ($urandom_range(0, 5))
			0:       return $urandom();
			1:       return '1;
			default: return $urandom_range(0, 15);
		endcase
	endfunction

	function automatic logic [QTY_W-1:0] pick_size();
		case ($urandom_range(0, 7))
			0:       return $urandom();
			1:       return '1;
			2:       return '0;
			default: return $urandom_range(1, 40);
		endcase
	endfunction

	// Incoming size: small, full range, or within one of the resting total so that the
	// FOK boundary gets hit from both sides.
	function automatic logic [QTY_W-1:0] pick_incoming();
		logic [TOTAL_W-1:0] near;
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 60);
			1: return $urandom();
			default: begin
				near = shadow_total + $urandom_range(0, 2);
				if (near != 0)
					near = near - 1;
				if (near > {{(TOTAL_W - QTY_W){1'b0}}, {QTY_W{1'b1}}})
					return '1;
				return near[QTY_W-1:0];
			end
		endcase
	endfunction

	function automatic logic [TIF_W-1:0] pick_tif();
		if ($urandom_range(0, 1) == 0)
			return TIF_FOK;
		return TIF_W'($urandom_range(0, 3));
	endfunction

	// ---------------------------------------------------------------------------------
	// Directed table: extremes, every time-in-force, FOK shortfall and exact cover,
	// zero sizes both sides, stamp ties and front insertion, empty-book match.
	// ---------------------------------------------------------------------------------
	order_row_t directed_rows [0:21] = '{
		// match on an empty book: no report at all
		'{OP_MATCH, 32'h0,        32'h0,        32'd5,        TIF_DAY,   1'b0, 32'h0,        32'h0},
		// all-ones order, tif field ignored on an add
		'{OP_ADD,   32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, TIF_SPARE, 1'b0, 32'h0,        32'h0},
		'{OP_MATCH, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, TIF_DAY,   1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF},
		// zero resting size, zero incoming size
		'{OP_ADD,   32'h0,        32'h0,        32'h0,        TIF_FOK,   1'b0, 32'h0,        32'h0},
		'{OP_MATCH, 32'h0,        32'h0,        32'h0,        TIF_IOC,   1'b1, 32'h0,        32'h0},
		// FOK one short of the book: killed
		'{OP_ADD,   32'd1,        32'd5,        32'd10,       TIF_DAY,   1'b0, 32'h0,        32'h0},
		'{OP_MATCH, 32'h0,        32'h0,        32'd11,       TIF_FOK,   1'b1, 32'd1,        32'd0},
		// FOK exactly covered
		'{OP_ADD,   32'd2,        32'd5,        32'd10,       TIF_DAY,   1'b0, 32'h0,        32'h0},
		'{OP_MATCH, 32'h0,        32'h0,        32'd10,       TIF_FOK,   1'b1, 32'd2,        32'd10},
		// spare code fills like DAY, partial fill
		'{OP_ADD,   32'd3,        32'd7,        32'd100,      TIF_IOC,   1'b0, 32'h0,        32'h0},
		'{OP_MATCH, 32'h0,        32'h0,        32'd40,       TIF_SPARE, 1'b1, 32'd3,        32'd40},
		// zero incoming against a live order
		'{OP_ADD,   32'd4,        32'd1,        32'd9,        TIF_DAY,   1'b0, 32'h0,        32'h0},
		'{OP_MATCH, 32'h0,        32'h0,        32'd0,        TIF_IOC,   1'b1, 32'd4,        32'd0},
		// tie on stamp 9 keeps load order; stamp 0 goes to the front
		'{OP_ADD,   32'd10,       32'd9,        32'd5,        TIF_DAY,   1'b0, 32'h0,        32'h0},
		'{OP_ADD,   32'd11,       32'd3,        32'd7,        TIF_DAY,   1'b0, 32'h0,        32'h0},
		'{OP_ADD,   32'd12,       32'd9,        32'd4,        TIF_DAY,   1'b0, 32'h0,        32'h0},
		'{OP_ADD,   32'd13,       32'd0,        32'd1,        TIF_DAY,   1'b0, 32'h0,        32'h0},
		'{OP_MATCH, 32'h0,        32'h0,        32'd10,       TIF_IOC,   1'b0, 32'h0,        32'h0},
		// book total above 32 bits against an all-ones FOK
		'{OP_ADD,   32'd20,       32'd20,       32'd50,       TIF_DAY,   1'b0, 32'h0,        32'h0},
		'{OP_ADD,   32'd21,       32'd10,       32'd0,        TIF_DAY,   1'b0, 32'h0,        32'h0},
		'{OP_ADD,   32'd22,       32'd20,       32'hFFFFFFFF, TIF_DAY,   1'b0, 32'h0,        32'h0},
		'{OP_MATCH, 32'h0,        32'h0,        32'hFFFFFFFF, TIF_FOK,   1'b0, 32'h0,        32'h0}
	};

	// ---------------------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------------------
	initial begin : stimulus
		fill_t typed_fill;
		int    pick;
		int    n_adds;
		bit    full_book_done;

		full_book_done       = 1'b0;
		shadow_total         = '0;
		arst_n               = 1'b0;
		orders.valid         = 1'b0;
		orders.operation     = OP_ADD;
		orders.order_tag     = '0;
		orders.arrival_stamp = '0;
		orders.quantity      = '0;
		orders.time_in_force = TIF_DAY;
		reports.ready        = 1'b0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			typed_fill.tag    = directed_rows[i].want_tag;
			typed_fill.amount = directed_rows[i].want_fill;
			typed_fill.last   = 1'b1;
			send_order(directed_rows[i].op, directed_rows[i].tag, directed_rows[i].stamp,
				directed_rows[i].qty, directed_rows[i].tif, directed_rows[i].typed, typed_fill);
		end

		// Random part: mostly short books (a few adds, then a match) with random content,
		// plus books carried over without a match and stray transactions. Once, after a
		// full drain, the book is filled past capacity.
		while (orders_accepted < $size(directed_rows) + RANDOM_ITEMS) begin
			if (!full_book_done && orders_accepted > $size(directed_rows) + RANDOM_ITEMS / 3) begin
				orders.valid <= 1'b0;
				while (expected_fills.size() != 0) @(posedge clk);
				repeat (DRAIN_CYCLES) @(posedge clk);
				repeat (MAX_ORDERS + 4)
					send_order(OP_ADD, $urandom(), pick_stamp(), pick_size(), pick_tif());
				send_order(OP_MATCH, $urandom(), $urandom(), pick_incoming(), pick_tif());
				full_book_done = 1'b1;
			end else begin
				pick = $urandom_range(0, 9);
				if ($urandom_range(0, 5) == 0)
					tx_calm = !tx_calm;
				n_adds = $urandom_range(0, 8);
				repeat (n_adds)
					send_order(OP_ADD, $urandom(), pick_stamp(), pick_size(), pick_tif());
				if (pick < 8)
					send_order(OP_MATCH, $urandom(), $urandom(), pick_incoming(), pick_tif());
				else if (pick == 8)
					send_order(1'($urandom_range(0, 1)), $urandom(), $urandom(), $urandom(),
						TIF_W'($urandom_range(0, 3)));
				// otherwise the book carries into the next sequence
			end
		end
		if (resting_book.size() != 0)
			send_order(OP_MATCH, $urandom(), $urandom(), pick_incoming(), pick_tif());
		orders.valid <= 1'b0;

		while (expected_fills.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d adds (%0d dropped on a full book) and %0d incoming orders, %0d FOK kills.",
			adds_accepted, adds_dropped, matches_accepted, fok_kills);
		$display("Checked %0d fill reports under random gaps and stalls of 0..%0d cycles.",
			reports_checked, MAX_IDLE);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// ---------------------------------------------------------------------------------
	// Receiver: random stall after each report, calm stretches with ready held high.
	// Every accepted report is compared field by field with the oldest expectation.
	// ---------------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : report_check
		fill_t want;
		int    stall;
		int    hold;
		if (!arst_n) begin
			reports.ready <= 1'b0;
			hold = 0;
		end else if (reports.valid && reports.ready) begin
			reports_checked++;
			if (expected_fills.size() == 0) begin
				$display("%0t: report with none expected: expected nothing, got tag %h amount %h last %b",
					$time, reports.report_tag, reports.filled_amount, reports.last_report);
				mismatches++;
			end else begin
				want = expected_fills.pop_front();
				if (reports.report_tag !== want.tag) begin
					$display("%0t: report_tag expected %h, got %h", $time, want.tag,
						reports.report_tag);
					mismatches++;
				end
				if (reports.filled_amount !== want.amount) begin
					$display("%0t: filled_amount expected %h, got %h", $time, want.amount,
						reports.filled_amount);
					mismatches++;
				end
				if (reports.last_report !== want.last) begin
					$display("%0t: last_report expected %b, got %b", $time, want.last,
						reports.last_report);
					mismatches++;
				end
			end
			if ($urandom_range(0, 29) == 0)
				rx_calm = !rx_calm;
			stall = rx_calm ? 0 : $urandom_range(0, MAX_IDLE);
			reports.ready <= (stall == 0);
			hold = stall;
		end else if (hold != 0) begin
			reports.ready <= (hold == 1);
			hold = hold - 1;
		end else begin
			reports.ready <= 1'b1;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

endmodule
